// ----- rtl/gtc_pkg.sv -----
// Shared constants, types, microcode program and month tables for the GPS time to calendar core.
package gtc_pkg;

	// fixed field widths and defaults
	localparam int WEEK_BITS_DEF = 13;
	localparam int TOW_W         = 30;
	localparam int YEAR_W        = 12;
	localparam int EPOCH_YEAR    = 1980;

	// millisecond constants, sized to the working remainder
	localparam logic [TOW_W-1:0] MS_PER_DAY  = TOW_W'(86400000);
	localparam logic [TOW_W-1:0] MS_PER_HOUR = TOW_W'(3600000);
	localparam logic [TOW_W-1:0] MS_PER_MIN  = TOW_W'(60000);
	localparam logic [TOW_W-1:0] MS_PER_SEC  = TOW_W'(1000);

	// GPS day 0 is the sixth day of the epoch year
	localparam int EPOCH_DAY_OFFSET = 5;

	// year residues kept alongside the year counter for the leap rule
	localparam logic [1:0] EPOCH_MOD4   = 2'(EPOCH_YEAR % 4);
	localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
	localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);

	// datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_SUB_DAY,
		OP_SAVE_DAYMS,
		OP_SUB_HOUR,
		OP_SUB_MIN,
		OP_SAVE_SEC,
		OP_SUB_SEC,
		OP_SNAP,
		OP_CARRY_SEC,
		OP_CARRY_MIN,
		OP_CARRY_HOUR,
		OP_SUB_YEAR,
		OP_SUB_MONTH,
		OP_EMIT
	} gtc_op_t;

	typedef logic [3:0] step_t;

	// program addresses
	localparam step_t ST_DAY     = 4'd0;
	localparam step_t ST_DAYMS   = 4'd1;
	localparam step_t ST_HOUR    = 4'd2;
	localparam step_t ST_MIN     = 4'd3;
	localparam step_t ST_SAVESEC = 4'd4;
	localparam step_t ST_SEC     = 4'd5;
	localparam step_t ST_SNAP    = 4'd6;
	localparam step_t ST_CSEC    = 4'd7;
	localparam step_t ST_CMIN    = 4'd8;
	localparam step_t ST_CHOUR   = 4'd9;
	localparam step_t ST_YEAR    = 4'd10;
	localparam step_t ST_MONTH   = 4'd11;
	localparam step_t ST_EMIT    = 4'd12;

	// control word: operation, next step when the test holds, next step otherwise
	typedef struct packed {
		gtc_op_t op;
		step_t   jmp_t;
		step_t   jmp_f;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		logic    busy;
		gtc_op_t op;
	} ctl_t;

	function automatic ucode_t ucode(input step_t s);
		ucode_t w;
		case (s)
			ST_DAY:     w = '{OP_SUB_DAY,    ST_DAY,     ST_DAYMS};
			ST_DAYMS:   w = '{OP_SAVE_DAYMS, ST_HOUR,    ST_HOUR};
			ST_HOUR:    w = '{OP_SUB_HOUR,   ST_HOUR,    ST_MIN};
			ST_MIN:     w = '{OP_SUB_MIN,    ST_MIN,     ST_SAVESEC};
			ST_SAVESEC: w = '{OP_SAVE_SEC,   ST_SEC,     ST_SEC};
			ST_SEC:     w = '{OP_SUB_SEC,    ST_SEC,     ST_SNAP};
			ST_SNAP:    w = '{OP_SNAP,       ST_CSEC,    ST_CSEC};
			ST_CSEC:    w = '{OP_CARRY_SEC,  ST_CMIN,    ST_CMIN};
			ST_CMIN:    w = '{OP_CARRY_MIN,  ST_CHOUR,   ST_CHOUR};
			ST_CHOUR:   w = '{OP_CARRY_HOUR, ST_YEAR,    ST_YEAR};
			ST_YEAR:    w = '{OP_SUB_YEAR,   ST_YEAR,    ST_MONTH};
			ST_MONTH:   w = '{OP_SUB_MONTH,  ST_MONTH,   ST_EMIT};
			ST_EMIT:    w = '{OP_EMIT,       ST_DAY,     ST_DAY};
			default:    w = '{OP_EMIT,       ST_DAY,     ST_DAY};
		endcase
		return w;
	endfunction

	// first day of month (0-based index, 12 = year length)
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
		logic [8:0] v;
		case (idx)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = leap ? 9'd60  : 9'd59;
			4'd3:    v = leap ? 9'd91  : 9'd90;
			4'd4:    v = leap ? 9'd121 : 9'd120;
			4'd5:    v = leap ? 9'd152 : 9'd151;
			4'd6:    v = leap ? 9'd182 : 9'd181;
			4'd7:    v = leap ? 9'd213 : 9'd212;
			4'd8:    v = leap ? 9'd244 : 9'd243;
			4'd9:    v = leap ? 9'd274 : 9'd273;
			4'd10:   v = leap ? 9'd305 : 9'd304;
			4'd11:   v = leap ? 9'd335 : 9'd334;
			4'd12:   v = leap ? 9'd366 : 9'd365;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/gtc_seq.sv -----
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module gtc_seq
	import gtc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic cond,
	output ctl_t ctl
);

	logic   busy_q, busy_d;
	step_t  step_q, step_d;
	ucode_t word;

	assign word = ucode(step_q);
	assign ctl  = '{busy: busy_q, op: word.op};

	always_comb begin
		busy_d = busy_q;
		step_d = step_q;
		if (!busy_q) begin
			if (go) begin
				busy_d = 1'b1;
				step_d = ST_DAY;
			end
		end else if (word.op == OP_EMIT) begin
			busy_d = 1'b0;
			step_d = ST_DAY;
		end else begin
			step_d = cond ? word.jmp_t : word.jmp_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_DAY;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
		end
	end

endmodule

// ----- rtl/gps_time_to_calendar_core.sv -----
// Top level: GPS week and time of week to calendar date and time of day.
// Sequence: whole days, hours, minutes and seconds are peeled off by subtraction, the seconds
// field is snapped and carried, years are walked from 1980 and months stepped, then the emit
// step issues the result and done follows it, registered.
// Throughput: one word at a time, busy from accept until the result word is issued.
// The year walk takes one year per cycle. done pulses one cycle, no stall.
// Reset clears the sequencer and the done strobe; the datapath registers are not reset.
module gps_time_to_calendar_core
	import gtc_pkg::*;
#(
	parameter int WEEK_BITS = WEEK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WEEK_BITS-1:0] gps_week,
	input  logic [TOW_W-1:0]     tow_ms,
	output logic                 done,
	output logic [YEAR_W-1:0]    cal_year,
	output logic [3:0]           cal_month,
	output logic [4:0]           cal_day,
	output logic [4:0]           cal_hour,
	output logic [5:0]           cal_minute,
	output logic [15:0]          second_ms,
	output logic [26:0]          day_ms
);

	// day count: week*7 + a few days from tow + offset stays below 2^(WEEK_BITS+4)
	localparam int DAY_BITS = WEEK_BITS + 4;

	ctl_t ctl;
	logic go;
	logic cond;

	// datapath registers
	logic [TOW_W-1:0]    rem_q;    // remainder being peeled
	logic [DAY_BITS-1:0] days_q;   // day count, then day of year
	logic [26:0]         dayms_q;  // ms into day, unsnapped
	logic [15:0]         sec_q;    // ms into minute
	logic [4:0]          hour_q;
	logic [5:0]          min_q;
	logic [YEAR_W-1:0]   year_q;
	logic [1:0]          y4_q;     // year mod 4
	logic [6:0]          y100_q;   // year mod 100
	logic [8:0]          y400_q;   // year mod 400
	logic [3:0]          month_q;
	logic [4:0]          dom_q;
	logic                done_q;

	logic          leap;
	logic [8:0]    ylen;
	logic [8:0]    mstart;
	logic [8:0]    mprev;
	logic [9:0]    frac;

	assign go   = start & ~ctl.busy;
	assign busy = ctl.busy;

	// Gregorian rule from the running residues
	assign leap   = (y4_q == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));
	assign ylen   = leap ? 9'd366 : 9'd365;
	assign mstart = month_start(leap, month_q);
	assign mprev  = month_start(leap, month_q - 4'd1);
	assign frac   = rem_q[9:0];

	gtc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.cond   (cond),
		.ctl    (ctl)
	);

	// jump test for the current control word
	always_comb begin
		case (ctl.op)
			OP_SUB_DAY:    cond = rem_q >= MS_PER_DAY;
			OP_SUB_HOUR:   cond = rem_q >= MS_PER_HOUR;
			OP_SUB_MIN:    cond = rem_q >= MS_PER_MIN;
			OP_SUB_SEC:    cond = rem_q >= MS_PER_SEC;
			OP_CARRY_SEC:  cond = sec_q == 16'(MS_PER_MIN);
			OP_CARRY_MIN:  cond = min_q == 6'd60;
			OP_CARRY_HOUR: cond = hour_q == 5'd24;
			OP_SUB_YEAR:   cond = days_q >= DAY_BITS'(ylen);
			OP_SUB_MONTH:  cond = (month_q < 4'd12) && (days_q >= DAY_BITS'(mstart));
			default:       cond = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q   <= tow_ms;
			days_q  <= DAY_BITS'({1'b0, gps_week, 3'b000}) - DAY_BITS'(gps_week)
			           + DAY_BITS'(EPOCH_DAY_OFFSET);
			hour_q  <= 5'd0;
			min_q   <= 6'd0;
			year_q  <= YEAR_W'(EPOCH_YEAR);
			y4_q    <= EPOCH_MOD4;
			y100_q  <= EPOCH_MOD100;
			y400_q  <= EPOCH_MOD400;
			month_q <= 4'd1;
		end else if (ctl.busy) begin
			case (ctl.op)
				OP_SUB_DAY: begin
					if (cond) begin
						rem_q  <= rem_q - MS_PER_DAY;
						days_q <= days_q + DAY_BITS'(1);
					end
				end
				OP_SAVE_DAYMS: dayms_q <= rem_q[26:0];
				OP_SUB_HOUR: begin
					if (cond) begin
						rem_q  <= rem_q - MS_PER_HOUR;
						hour_q <= hour_q + 5'd1;
					end
				end
				OP_SUB_MIN: begin
					if (cond) begin
						rem_q <= rem_q - MS_PER_MIN;
						min_q <= min_q + 6'd1;
					end
				end
				OP_SAVE_SEC: sec_q <= rem_q[15:0];
				OP_SUB_SEC: begin
					if (cond) rem_q <= rem_q - MS_PER_SEC;
				end
				OP_SNAP: begin
					// within 10 ms of a whole second: snap to it
					if (frac < 10'd10) sec_q <= sec_q - 16'(frac);
					else if (frac > 10'd990) sec_q <= sec_q + 16'(10'd1000 - frac);
				end
				OP_CARRY_SEC: begin
					if (cond) begin
						sec_q <= 16'd0;
						min_q <= min_q + 6'd1;
					end
				end
				OP_CARRY_MIN: begin
					if (cond) begin
						min_q  <= 6'd0;
						hour_q <= hour_q + 5'd1;
					end
				end
				OP_CARRY_HOUR: begin
					if (cond) begin
						hour_q <= 5'd0;
						days_q <= days_q + DAY_BITS'(1);
					end
				end
				OP_SUB_YEAR: begin
					if (cond) begin
						days_q <= days_q - DAY_BITS'(ylen);
						year_q <= year_q + YEAR_W'(1);
						y4_q   <= y4_q + 2'd1;
						y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
						y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
					end
				end
				OP_SUB_MONTH: begin
					if (cond) month_q <= month_q + 4'd1;
				end
				OP_EMIT: dom_q <= 5'(days_q[8:0] - mprev + 9'd1);
				default: ;
			endcase
		end
	end

	// result strobe follows the emit step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.busy && (ctl.op == OP_EMIT);
		end
	end

	assign done       = done_q;
	assign cal_year   = year_q;
	assign cal_month  = month_q;
	assign cal_day    = dom_q;
	assign cal_hour   = hour_q;
	assign cal_minute = min_q;
	assign second_ms  = sec_q;
	assign day_ms     = dayms_q;

endmodule
